// File: sv/pds_pkg.sv
// Shared widths, constants and handshake types for the PLL divider search.
package pds_pkg;

  // Field widths.
  localparam int TGT_W   = 30;  // target in Hz
  localparam int REF_W   = 27;  // reference in Hz
  localparam int TGT_U_W = 27;  // target in 10 Hz units
  localparam int REF_U_W = 24;  // reference in 10 Hz units
  localparam int DIV_W   = 6;   // input divider
  localparam int MULT_W  = 9;   // feedback multiplier
  localparam int VCO_W   = 18;  // VCO input in 10 Hz units, window-checked
  localparam int PROD_W  = 33;  // target units times divider
  localparam int REFMIN_W = 32; // reference units times minimum multiplier

  // Serial divider datapath widths.
  localparam int NUM_W  = PROD_W;
  localparam int DEN_W  = REF_U_W;
  localparam int QUO_W  = TGT_U_W;
  localparam int STEP_W = 5;

  // Serial multiplier widths.
  localparam int ACH_W     = VCO_W + MULT_W;
  localparam int MUL_CNT_W = 4;

  // Quotient bits produced by each division.
  localparam logic [STEP_W-1:0] STEPS_TGT  = STEP_W'(TGT_U_W);
  localparam logic [STEP_W-1:0] STEPS_REF  = STEP_W'(REF_U_W);
  localparam logic [STEP_W-1:0] STEPS_MULT = STEP_W'(MULT_W);
  localparam logic [STEP_W-1:0] STEPS_VCO  = STEP_W'(VCO_W);

  // Search constants.
  localparam logic [DEN_W-1:0]   UNIT_HZ       = DEN_W'(10);
  localparam logic [DIV_W-1:0]   MIN_DIVIDER   = DIV_W'(2);
  localparam logic [MULT_W-1:0]  MIN_MULT      = MULT_W'(192);
  localparam logic [REF_U_W-1:0] VCO_LO        = REF_U_W'(100000);
  localparam logic [REF_U_W-1:0] VCO_HI_P1     = REF_U_W'(200001);
  localparam logic [REF_U_W-1:0] VCO_LO_START  = REF_U_W'(200000);
  localparam logic [REF_U_W-1:0] VCO_HI_START  = REF_U_W'(400002);

  // Configuration port.
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [0:0] REG_REFERENCE = 1'b0;
  localparam logic [REF_W-1:0] REFERENCE_RESET = REF_W'(8000000);

  // Request to the serial divider.
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

// File: sv/pds_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pds_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pds_pkg::div_req_t             req,
  input  logic [pds_pkg::NUM_W-1:0]     num,
  input  logic [pds_pkg::DEN_W-1:0]     den,
  output logic [pds_pkg::QUO_W-1:0]     quo,
  output logic                          done
);
  import pds_pkg::*;

  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  den_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [NUM_W-1:0]  den_load;
  logic              fits;

  // The divisor starts aligned to the top quotient bit the caller asks for.
  assign den_load = NUM_W'(den) << (req.steps - STEP_W'(1));
  assign fits     = (rem_r >= den_r);

  // Control: run flag and the one-cycle done pulse after the last bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && (cnt_r == STEP_W'(1));
      if (req.start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == STEP_W'(1))) begin
        run_r <= 1'b0;
      end
    end
  end

  // Datapath: subtract the shifted divisor where it fits and shift in one bit.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= num;
      den_r <= den_load;
      quo_r <= '0;
      cnt_r <= req.steps;
    end else if (run_r) begin
      if (fits) begin
        rem_r <= rem_r - den_r;
      end
      quo_r <= {quo_r[QUO_W-2:0], fits};
      den_r <= den_r >> 1;
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// File: sv/pds_mul.sv
// Bit-serial shift-and-add multiplier for VCO input times multiplier.
module pds_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pds_pkg::VCO_W-1:0]     a,
  input  logic [pds_pkg::MULT_W-1:0]    b,
  output logic [pds_pkg::ACH_W-1:0]     prod,
  output logic                          done
);
  import pds_pkg::*;

  logic [ACH_W-1:0]     acc_r;
  logic [ACH_W-1:0]     a_r;
  logic [MULT_W-1:0]    b_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;

  // Control: run flag and done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && (cnt_r == MUL_CNT_W'(1));
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == MUL_CNT_W'(1))) begin
        run_r <= 1'b0;
      end
    end
  end

  // Datapath: one multiplier bit per cycle, LSB first.
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= ACH_W'(a);
      b_r   <= b;
      cnt_r <= MUL_CNT_W'(MULT_W);
    end else if (run_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r   <= a_r << 1;
      b_r   <= b_r >> 1;
      cnt_r <= cnt_r - MUL_CNT_W'(1);
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

// File: sv/pds_apb.sv
// APB-style configuration register holding the reference frequency.
module pds_apb (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pds_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pds_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pds_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [pds_pkg::REF_W-1:0]        reference_hz
);
  import pds_pkg::*;

  logic [REF_W-1:0] reference_hz_r;
  logic [0:0]       reg_idx;
  logic             wr_beat;

  // Word index above the byte lanes selects the register.
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite && pready;

  // Reference register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reference_hz_r <= REFERENCE_RESET;
    end else if (wr_beat && (reg_idx == REG_REFERENCE)) begin
      reference_hz_r <= pwdata[REF_W-1:0];
    end
  end

  // Read back; unmapped words read as zero.
  assign prdata = (reg_idx == REG_REFERENCE) ? CFG_DATA_W'(reference_hz_r) : '0;

  assign reference_hz = reference_hz_r;

endmodule

// File: sv/pll_divider_search.sv
// The search time grows with k (at most 32), the number of dividers whose VCO input and
// multiplier fall in range: each of them costs two divisions and one multiplication.
// An exact hit ends the search early. busy stays high through the result beat, so a new
// command is taken at the earliest once the result beat of the previous one is over.
// The time is set by the shared bit-serial divider (one quotient bit per cycle) and the
// bit-serial multiplier. Each result beat is shown for one cycle; the receiver cannot stall.
// Reset is synchronous: the sequencer goes idle and the reference register returns to 8 MHz.
module pll_divider_search #(
  parameter int MAX_DIVIDER    = 63,
  parameter int MAX_MULTIPLIER = 432
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pds_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pds_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pds_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  // Command channel.
  input  logic                             start,
  output logic                             busy,
  input  logic [pds_pkg::TGT_W-1:0]        in_target_hz,
  // Result channel.
  output logic                             out_valid,
  output logic [pds_pkg::DIV_W-1:0]        out_divider,
  output logic [pds_pkg::MULT_W-1:0]       out_multiplier,
  output logic                             out_found,
  output logic                             out_exact
);
  import pds_pkg::*;

  localparam logic [DIV_W-1:0] MAX_D   = DIV_W'(MAX_DIVIDER);
  localparam logic [9:0]       MAXM_P1 = 10'(MAX_MULTIPLIER + 1);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_DIV_TGT = 10'b00_0000_0010,
    ST_DIV_REF = 10'b00_0000_0100,
    ST_SCALE   = 10'b00_0000_1000,
    ST_CHECK   = 10'b00_0001_0000,
    ST_DIV_M   = 10'b00_0010_0000,
    ST_DIV_V   = 10'b00_0100_0000,
    ST_MUL     = 10'b00_1000_0000,
    ST_CMP     = 10'b01_0000_0000,
    ST_DONE    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [REF_W-1:0]    reference_hz;
  logic [TGT_U_W-1:0]  tgt_u_r;
  logic [REF_U_W-1:0]  ref_u_r;
  logic [PROD_W-1:0]   prod_r;
  logic [REF_U_W-1:0]  lo_r;
  logic [REF_U_W-1:0]  hi_r;
  logic [PROD_W-1:0]   ref_max_r;
  logic [REFMIN_W-1:0] ref_min_r;
  logic [DIV_W-1:0]    d_r;
  logic [MULT_W-1:0]   m_r;
  logic [TGT_U_W-1:0]  err_r;
  logic [TGT_U_W-1:0]  best_err_r;
  logic [DIV_W-1:0]    best_d_r;
  logic [MULT_W-1:0]   best_m_r;
  logic                found_r;

  logic                accept;
  logic                win_ok;
  logic                mult_ok;
  logic                pass;
  logic                better;
  logic                hit;
  logic                last_d;
  logic                advance;
  logic [33:0]         ref_max_full;
  logic [REFMIN_W-1:0] ref_min_full;

  div_req_t            div_req;
  logic [NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  logic [QUO_W-1:0]    div_quo;
  logic                div_done;
  logic                mul_start;
  logic [ACH_W-1:0]    mul_prod;
  logic                mul_done;

  // Configuration register.
  pds_apb u_apb (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .reference_hz (reference_hz)
  );

  // Shared serial divider and serial multiplier.
  pds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  pds_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (div_quo[VCO_W-1:0]),
    .b     (m_r),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Window test without division: 100000*d <= ref < 200001*d.
  assign win_ok  = (ref_u_r >= lo_r) && (ref_u_r < hi_r);
  // Multiplier range test: 192*ref <= target*d < (max+1)*ref.
  assign mult_ok = (prod_r >= PROD_W'(ref_min_r)) && (prod_r < ref_max_r);
  assign pass    = win_ok && mult_ok;

  assign better  = (err_r < best_err_r);
  assign hit     = better && (err_r == '0);
  assign last_d  = (d_r == MAX_D);
  assign advance = ((state_r == ST_CHECK) && !pass) || ((state_r == ST_CMP) && !hit);

  assign ref_max_full = ref_u_r * MAXM_P1;
  assign ref_min_full = ref_u_r * REFMIN_W'(MIN_MULT);

  // Divider requests, one per phase of the search.
  always_comb begin
    div_req = '{start: 1'b0, steps: '0};
    div_num = '0;
    div_den = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          div_req = '{start: 1'b1, steps: STEPS_TGT};
          div_num = NUM_W'(in_target_hz);
          div_den = UNIT_HZ;
        end
      end
      ST_DIV_TGT: begin
        if (div_done) begin
          div_req = '{start: 1'b1, steps: STEPS_REF};
          div_num = NUM_W'(reference_hz);
          div_den = UNIT_HZ;
        end
      end
      ST_CHECK: begin
        if (pass) begin
          div_req = '{start: 1'b1, steps: STEPS_MULT};
          div_num = prod_r;
          div_den = ref_u_r;
        end
      end
      ST_DIV_M: begin
        if (div_done) begin
          div_req = '{start: 1'b1, steps: STEPS_VCO};
          div_num = NUM_W'(ref_u_r);
          div_den = DEN_W'(d_r);
        end
      end
      default: begin
        div_req = '{start: 1'b0, steps: '0};
      end
    endcase
  end

  assign mul_start = (state_r == ST_DIV_V) && div_done;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (accept)   state_nxt = ST_DIV_TGT;
      ST_DIV_TGT: if (div_done) state_nxt = ST_DIV_REF;
      ST_DIV_REF: if (div_done) state_nxt = ST_SCALE;
      ST_SCALE:   state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (pass) begin
          state_nxt = ST_DIV_M;
        end else if (last_d) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV_M:   if (div_done) state_nxt = ST_DIV_V;
      ST_DIV_V:   if (div_done) state_nxt = ST_MUL;
      ST_MUL:     if (mul_done) state_nxt = ST_CMP;
      ST_CMP: begin
        if (hit || last_d) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Search datapath.
  always_ff @(posedge clk) begin
    if ((state_r == ST_DIV_TGT) && div_done) begin
      tgt_u_r <= div_quo;
    end
    // Start the sweep at the smallest divider.
    if ((state_r == ST_DIV_REF) && div_done) begin
      ref_u_r    <= div_quo[REF_U_W-1:0];
      d_r        <= MIN_DIVIDER;
      prod_r     <= PROD_W'(tgt_u_r) << 1;
      lo_r       <= VCO_LO_START;
      hi_r       <= VCO_HI_START;
      best_err_r <= tgt_u_r;
      best_d_r   <= MAX_D;
      best_m_r   <= MIN_MULT;
      found_r    <= 1'b0;
    end
    if (state_r == ST_SCALE) begin
      ref_max_r <= ref_max_full[PROD_W-1:0];
      ref_min_r <= ref_min_full;
    end
    // Step to the next divider; the scaled bounds grow by adding.
    if (advance && !last_d) begin
      d_r    <= d_r + DIV_W'(1);
      prod_r <= prod_r + PROD_W'(tgt_u_r);
      lo_r   <= lo_r + VCO_LO;
      hi_r   <= hi_r + VCO_HI_P1;
    end
    if ((state_r == ST_DIV_M) && div_done) begin
      m_r <= div_quo[MULT_W-1:0];
    end
    // The achieved frequency never exceeds the target.
    if ((state_r == ST_MUL) && mul_done) begin
      err_r <= tgt_u_r - mul_prod;
    end
    if ((state_r == ST_CMP) && better) begin
      best_err_r <= err_r;
      best_d_r   <= d_r;
      best_m_r   <= m_r;
      found_r    <= 1'b1;
    end
  end

  // Result beat.
  assign out_valid      = (state_r == ST_DONE);
  assign out_divider    = best_d_r;
  assign out_multiplier = best_m_r;
  assign out_found      = found_r;
  assign out_exact      = found_r && (best_err_r == '0);

  // Checks.
  a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy did not drop after the result beat");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted command did not start a search");

  a_exact_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_exact) |-> out_found)
    else $error("exact reported without a found setting");

  a_not_found_default: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> ((out_divider == MAX_D) && (out_multiplier == MIN_MULT)))
    else $error("default setting not reported when nothing qualified");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |->
      ((out_multiplier >= MIN_MULT) && (out_multiplier < MAXM_P1[MULT_W:0])
       && (out_divider >= MIN_DIVIDER) && (out_divider <= MAX_D)))
    else $error("found setting out of range");

endmodule

// File: tb/sv/pll_divider_search_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each PLL divider search result and compares every result beat.
module pll_divider_search_checker #(
  parameter int MAX_DIVIDER    = 63,
  parameter int MAX_MULTIPLIER = 432,
  parameter logic [pds_pkg::CFG_ADDR_W-1:0] REFERENCE_ADDR = '0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pds_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pds_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [pds_pkg::CFG_DATA_W-1:0] prdata,
  input  logic                           pready,
  input  logic                           start,
  input  logic                           busy,
  input  logic [pds_pkg::TGT_W-1:0]      in_target_hz,
  input  logic                           out_valid,
  input  logic [pds_pkg::DIV_W-1:0]      out_divider,
  input  logic [pds_pkg::MULT_W-1:0]     out_multiplier,
  input  logic                           out_found,
  input  logic                           out_exact,
  output int                             fail_count,
  output int                             pending_count
);
  import pds_pkg::*;

  typedef struct packed {
    logic [DIV_W-1:0]  divider;
    logic [MULT_W-1:0] multiplier;
    logic              found;
    logic              exact;
  } pll_setting_t;

  // Our own copy of the reference register and the settings still owed by the block.
  logic [REF_W-1:0] reference_model = REFERENCE_RESET;
  pll_setting_t     expected_settings[$];
  int               errors = 0;

  // Walks input dividers upward until an exact hit and keeps the first with the least error.
  function automatic pll_setting_t search_pll_setting(input logic [REF_W-1:0] ref_hz,
                                                      input logic [TGT_W-1:0] tgt_hz);
    longint unsigned ref_u, tgt_u, best_err, vco, mult, achieved, err;
    int              d;
    bit              hit_exact;
    pll_setting_t    best;
    ref_u = 64'(ref_hz);
    ref_u = ref_u / UNIT_HZ;
    tgt_u = 64'(tgt_hz);
    tgt_u = tgt_u / UNIT_HZ;
    best_err = tgt_u;
    hit_exact = 1'b0;
    best.divider    = DIV_W'(MAX_DIVIDER);
    best.multiplier = MIN_MULT;
    best.found      = 1'b0;
    best.exact      = 1'b0;
    // A zero reference never meets the VCO input window, so it skips the whole search.
    if (ref_u != 0) begin
      for (d = int'(MIN_DIVIDER); d <= MAX_DIVIDER && !hit_exact; d++) begin
        vco  = ref_u / 64'(d);
        mult = (tgt_u * 64'(d)) / ref_u;
        if (vco >= VCO_LO && vco < VCO_HI_P1 && mult >= MIN_MULT && mult <= MAX_MULTIPLIER) begin
          achieved = vco * mult;
          err = (tgt_u >= achieved) ? tgt_u - achieved : achieved - tgt_u;
          if (err < best_err) begin
            best_err        = err;
            best.divider    = DIV_W'(d);
            best.multiplier = MULT_W'(mult);
            best.found      = 1'b1;
            hit_exact       = (err == 0);
          end
        end
      end
    end
    best.exact = best.found && best_err == 0;
    return best;
  endfunction

  task automatic compare_field(input string what, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Result beats are checked before a new command is taken in, though a beat and an accepted
  // command never share one edge, since busy is high during the beat.
  always @(posedge clk) begin : monitor
    pll_setting_t want;
    if (!rst_n) begin
      reference_model = REFERENCE_RESET;
      expected_settings.delete();
    end else begin
      if (out_valid) begin
        if (expected_settings.size() == 0) begin
          $display("%0t: unexpected result beat: divider %0d multiplier %0d found %0b exact %0b",
                   $time, out_divider, out_multiplier, out_found, out_exact);
          errors++;
        end else begin
          want = expected_settings.pop_front();
          compare_field("divider", 64'(want.divider), 64'(out_divider));
          compare_field("multiplier", 64'(want.multiplier), 64'(out_multiplier));
          compare_field("found", 64'(want.found), 64'(out_found));
          compare_field("exact", 64'(want.exact), 64'(out_exact));
        end
      end
      if (start && !busy) begin
        expected_settings.push_back(search_pll_setting(reference_model, in_target_hz));
      end
      // Register access phase: writes update the copy, reads must return it.
      if (psel && penable && pready && paddr == REFERENCE_ADDR) begin
        if (pwrite) begin
          reference_model = pwdata[REF_W-1:0];
        end else begin
          compare_field("reference readback", 64'(reference_model), 64'(prdata));
        end
      end
    end
    fail_count    <= errors;
    pending_count <= expected_settings.size();
  end

endmodule

// File: tb/sv/tb_pll_divider_search.sv
`timescale 1ns / 1ps
// Testbench top: drives commands and reference writes into the PLL divider search.
module tb_pll_divider_search;
  import pds_pkg::*;

  localparam int MAX_DIVIDER        = 63;
  localparam int MAX_MULTIPLIER     = 432;
  localparam int IDLE_LIMIT         = 10000;
  localparam int BEATS_PER_SETTING  = 30;
  localparam int SETTING_COUNT      = 9;
  localparam logic [CFG_ADDR_W-1:0] REFERENCE_ADDR = CFG_ADDR_W'(4 * REG_REFERENCE);
  localparam logic [REF_W-1:0]      REFERENCE_MAX  = '1;
  localparam logic [TGT_W-1:0]      TARGET_MAX     = '1;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  start   = 1'b0;
  logic                  busy;
  logic [TGT_W-1:0]      in_target_hz = '0;
  logic                  out_valid;
  logic [DIV_W-1:0]      out_divider;
  logic [MULT_W-1:0]     out_multiplier;
  logic                  out_found;
  logic                  out_exact;
  int                    fail_count;
  int                    pending_count;
  int                    idle_cycles = 0;
  logic [REF_W-1:0]      reference_now = REFERENCE_RESET;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pll_divider_search #(
    .MAX_DIVIDER   (MAX_DIVIDER),
    .MAX_MULTIPLIER(MAX_MULTIPLIER)
  ) i_dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .in_target_hz,
    .out_valid, .out_divider, .out_multiplier, .out_found, .out_exact
  );

  pll_divider_search_checker #(
    .MAX_DIVIDER   (MAX_DIVIDER),
    .MAX_MULTIPLIER(MAX_MULTIPLIER),
    .REFERENCE_ADDR(REFERENCE_ADDR)
  ) i_checker (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .in_target_hz,
    .out_valid, .out_divider, .out_multiplier, .out_found, .out_exact,
    .fail_count, .pending_count
  );

  // Watchdog: any accepted beat or register access restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Holds start high until the block takes the command; start is left high for the caller.
  task automatic issue_target(input logic [TGT_W-1:0] target);
    start        <= 1'b1;
    in_target_hz <= target;
    do @(posedge clk); while (busy);
  endtask

  task automatic apb_transfer(input bit is_write, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= REFERENCE_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Every command yields one result, so idle means nothing pending and busy low.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0 || busy);
  endtask

  task automatic set_reference(input logic [REF_W-1:0] value);
    wait_idle();
    reference_now = value;
    apb_transfer(1'b1, CFG_DATA_W'(value));
    apb_transfer(1'b0, '0);
  endtask

  // A mix of targets the current reference can reach exactly, in-band targets and raw noise.
  function automatic logic [TGT_W-1:0] pick_target(input logic [REF_W-1:0] ref_hz);
    int unsigned     kind, d_lo, d_hi, d, m;
    longint unsigned ref_u, vco;
    kind  = $urandom_range(0, 9);
    ref_u = 64'(ref_hz / 10);
    d_lo  = 32'(ref_u / 200001 + 1);
    d_hi  = 32'(ref_u / 100000);
    if (d_lo < MIN_DIVIDER) d_lo = 32'(MIN_DIVIDER);
    if (d_hi > MAX_DIVIDER) d_hi = MAX_DIVIDER;
    if (kind < 4 && d_lo <= d_hi) begin
      d   = $urandom_range(d_lo, d_hi);
      m   = $urandom_range(MIN_MULT, MAX_MULTIPLIER);
      vco = ref_u / d;
      return TGT_W'(vco * m * 10 + $urandom_range(0, 9));
    end else if (kind < 8) begin
      return TGT_W'($urandom_range(180000000, 880000000));
    end else if (kind == 8) begin
      return TGT_W'($urandom());
    end else begin
      return TGT_W'($urandom_range(0, 200000000));
    end
  endfunction

  initial begin : stimulus
    logic [REF_W-1:0] settings[SETTING_COUNT];
    int               p, i;
    bit               idling;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apb_transfer(1'b0, '0);

    // Directed part at the reset reference of 8 MHz: zero and sub-unit targets, range edges,
    // exact hits, near misses and targets too large for any multiplier.
    issue_target('0);
    issue_target(TGT_W'(9));
    issue_target(TGT_W'(10));
    issue_target(TGT_W'(600000000));
    issue_target(TGT_W'(192000000));
    issue_target(TGT_W'(191999999));
    issue_target(TGT_W'(864000000));
    issue_target(TGT_W'(864000010));
    issue_target(TGT_W'(866000000));
    issue_target(TARGET_MAX);
    issue_target(TGT_W'(536870912));
    issue_target(TGT_W'(268435455));
    issue_target(TGT_W'(333333333));
    issue_target(TGT_W'(555555555));
    issue_target(TGT_W'(250000005));

    // A zero reference and one just too small: nothing can qualify.
    set_reference('0);
    issue_target(TGT_W'(600000000));
    issue_target('0);
    set_reference(REF_W'(1999999));
    issue_target(TGT_W'(400000000));
    // References that put the VCO input right on the window edges.
    set_reference(REF_W'(2000000));
    issue_target(TGT_W'(192000000));
    set_reference(REF_W'(4000000));
    issue_target(TGT_W'(400000000));
    issue_target(TGT_W'(864000000));

    // Random part over several reference settings; the last one runs without idling.
    settings = '{REFERENCE_MAX, REF_W'(100000000), REF_W'(25000000), REF_W'(12288000),
                 REF_W'($urandom_range(2000000, 134217727)),
                 REF_W'($urandom_range(2000000, 134217727)),
                 REF_W'($urandom_range(0, 2500000)),
                 REF_W'(4000000), REFERENCE_RESET};
    for (p = 0; p < SETTING_COUNT; p++) begin
      set_reference(settings[p]);
      idling = (p != SETTING_COUNT - 1);
      for (i = 0; i < BEATS_PER_SETTING; i++) begin
        issue_target(pick_target(reference_now));
        // An idle burst lands either inside the search or after the block has gone idle.
        if (idling && $urandom_range(0, 2) == 0) begin
          start <= 1'b0;
          if ($urandom_range(0, 1) == 1) begin
            do @(posedge clk); while (busy);
          end
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end

    wait_idle();
    repeat (1500) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
